// ===== hdl/fft_radix2_dif_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the FFT block.
// ---------------------------------------------------------------------------
`ifndef FFT_RADIX2_DIF_MACROS_SVH
`define FFT_RADIX2_DIF_MACROS_SVH

// A property that must hold on every clock edge outside reset.
`define FFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// An implication checked on the cycle after the antecedent.
`define FFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fft_pkg.sv =====
// ---------------------------------------------------------------------------
// FFT package
// Shared widths, twiddle table and a saturation helper.
// ---------------------------------------------------------------------------
package fft_pkg;

    localparam int SampleW = 16;
    localparam int WorkW   = 23;
    localparam int LogW    = 3;
    localparam int MaxLog  = 6;

    typedef logic signed [WorkW-1:0] work_t;

    // Quarter-wave cosine table in Q1.15, unity saturated.
    function automatic logic [15:0] quarter_cos(input logic [4:0] k);
        logic [15:0] r;
        unique case (k)
            5'd0:  r = 16'd32767;
            5'd1:  r = 16'd32610;
            5'd2:  r = 16'd32138;
            5'd3:  r = 16'd31357;
            5'd4:  r = 16'd30274;
            5'd5:  r = 16'd28899;
            5'd6:  r = 16'd27246;
            5'd7:  r = 16'd25330;
            5'd8:  r = 16'd23170;
            5'd9:  r = 16'd20788;
            5'd10: r = 16'd18205;
            5'd11: r = 16'd15447;
            5'd12: r = 16'd12540;
            5'd13: r = 16'd9512;
            5'd14: r = 16'd6393;
            5'd15: r = 16'd3212;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // Saturate a 25-bit sum to the working range.
    function automatic work_t sat_sum(input logic signed [24:0] v);
        work_t r;
        if (v > 25'sd4194303)
            r = 23'sd4194303;
        else if (v < -25'sd4194304)
            r = -23'sd4194304;
        else
            r = v[WorkW-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/fft_radix2_dif.sv =====
// Frame-based radix-2 DIF FFT. A frame of N = 2^size_log2 samples (4 to
// MAX_POINTS, at most 64) is loaded one per transaction. After the last
// sample the block runs (N/2)*log2(N) butterflies on one shared butterfly
// unit, each in two memory reads and four multiply and write steps, then
// emits N bins in natural order; each bin's memory read lands in the output
// register before the next read is issued. s_ready is low from the last
// sample until the last bin leaves, and while a size write is offered.
// Bins are unscaled and saturate to 23 bits.
// ---------------------------------------------------------------------------
// FFT top level
// Loads a frame, transforms it in place and emits the bins.
// ---------------------------------------------------------------------------
`include "fft_radix2_dif_macros.svh"

module fft_radix2_dif #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fft_pkg::LogW-1:0]            cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [fft_pkg::SampleW-1:0]  s_sample_re,
    input  logic signed [fft_pkg::SampleW-1:0]  s_sample_im,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fft_pkg::WorkW-1:0]    m_bin_re,
    output logic signed [fft_pkg::WorkW-1:0]    m_bin_im,
    output logic [5:0]                          m_bin_index,
    output logic                                m_last_bin
);
    import fft_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int LogLim = (AW > MaxLog) ? MaxLog : AW;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_RD_A  = 3'd1;
    localparam logic [2:0] ST_RD_B  = 3'd2;
    localparam logic [2:0] ST_MUL1  = 3'd3;
    localparam logic [2:0] ST_MUL2  = 3'd4;
    localparam logic [2:0] ST_WR_A  = 3'd5;
    localparam logic [2:0] ST_WR_B  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0]    state_reg;
    logic [LogW-1:0] size_reg;
    logic [AW:0]   fill_reg;
    logic [2:0]    stage_reg;   // current span log, counts down
    logic [AW-1:0] bfly_reg;    // butterfly number within the stage
    logic [AW:0]   emit_reg;    // read pointer for the output
    logic [AW:0]   sent_reg;    // bins delivered
    logic          rd_pend_reg; // a read is in flight to the output stage

    logic [2:0]    eff_log;
    logic [AW:0]   npts;

    // Effective size clamped to the supported range.
    always_comb begin
        eff_log = size_reg;
        if (eff_log < 3'd2) eff_log = 3'd2;
        if (eff_log > 3'(LogLim)) eff_log = 3'(LogLim);
    end
    assign npts = (AW+1)'(1) << eff_log;

    // Butterfly addressing: half = 2^(stage-1); l = bfly mod half.
    logic [AW-1:0] half_w, lidx, aaddr, baddr, grp;
    logic [4:0]    tw_k;
    assign half_w = AW'(1) << (stage_reg - 3'd1);
    assign lidx   = bfly_reg & (half_w - AW'(1));
    assign grp    = bfly_reg & ~(half_w - AW'(1));
    assign aaddr  = (grp << 1) | lidx;
    assign baddr  = aaddr | half_w;
    assign tw_k   = 5'((6'(lidx) << (3'd6 - stage_reg)) & 6'd31);

    // Twiddle lookup.
    logic signed [16:0] tw_c, tw_s;
    always_comb begin
        if (tw_k <= 5'd16) begin
            tw_c = $signed({1'b0, quarter_cos(tw_k)});
            tw_s = $signed({1'b0, quarter_cos(5'(5'd16 - tw_k))});
        end else begin
            tw_c = -$signed({1'b0, quarter_cos(5'(6'd32 - 6'(tw_k)))});
            tw_s = $signed({1'b0, quarter_cos(5'(tw_k - 5'd16))});
        end
    end

    // Memory ports.
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    work_t         wr_re, wr_im, rd_re, rd_im;

    fft_ram #(.Width(WorkW), .Depth(MAX_POINTS)) u_ram_re (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_re),
        .rd_addr(rd_addr), .rd_data(rd_re)
    );
    fft_ram #(.Width(WorkW), .Depth(MAX_POINTS)) u_ram_im (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_im),
        .rd_addr(rd_addr), .rd_data(rd_im)
    );

    // Butterfly datapath registers.
    work_t a_re_reg, a_im_reg, d_re_reg, d_im_reg;
    logic signed [39:0] p1_reg, p2_reg;
    logic signed [40:0] acc_reg;
    work_t sum_re, sum_im, dif_re, dif_im;
    assign sum_re = sat_sum(25'(a_re_reg) + 25'(rd_re));
    assign sum_im = sat_sum(25'(a_im_reg) + 25'(rd_im));
    assign dif_re = sat_sum(25'(a_re_reg) - 25'(rd_re));
    assign dif_im = sat_sum(25'(a_im_reg) - 25'(rd_im));

    // Rounding half up of a product sum, then saturation.
    function automatic work_t round_sat(input logic signed [40:0] v);
        logic signed [40:0] t;
        logic signed [25:0] q;
        work_t r;
        t = v + 41'sd16384;
        q = t[40:15];
        if (q > 26'sd4194303) r = 23'sd4194303;
        else if (q < -26'sd4194304) r = -23'sd4194304;
        else r = q[WorkW-1:0];
        return r;
    endfunction

    // Output stage: one registered bin.
    work_t         ob_re_reg, ob_im_reg;
    logic [5:0]    ob_idx_reg;
    logic          ob_last_reg, ob_valid_reg;
    logic [AW-1:0] emit_rev;
    logic [AW:0]   rd_idx_reg;
    logic          emit_fire;

    always_comb begin
        emit_rev = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < int'(eff_log)) emit_rev[i] = emit_reg[int'(eff_log) - 1 - i];
        end
    end
    // Issue a read only when the output register will be free for it.
    assign emit_fire = (state_reg == ST_EMIT) && (emit_reg < npts) && !rd_pend_reg
                       && (!ob_valid_reg || m_ready);

    // Memory control.
    always_comb begin
        wr_en = 1'b0; wr_addr = aaddr; wr_re = sum_re; wr_im = sum_im;
        rd_addr = aaddr;
        unique case (state_reg)
            ST_LOAD: begin
                wr_en = s_valid && s_ready;
                wr_addr = fill_reg[AW-1:0] & AW'(npts - (AW+1)'(1));
                wr_re = WorkW'(s_sample_re);
                wr_im = WorkW'(s_sample_im);
            end
            ST_RD_A: rd_addr = aaddr;
            ST_RD_B: rd_addr = baddr;
            ST_MUL1: begin
                wr_en = 1'b1; wr_addr = aaddr; wr_re = sum_re; wr_im = sum_im;
            end
            ST_MUL2: ;
            ST_WR_A: ;
            ST_WR_B: begin
                wr_en = 1'b1; wr_addr = baddr;
                if (lidx == '0) begin
                    wr_re = d_re_reg; wr_im = d_im_reg;
                end else begin
                    wr_re = a_re_reg; wr_im = round_sat(acc_reg);
                end
            end
            ST_EMIT: rd_addr = emit_rev;
            default: ;
        endcase
    end

    // A size write takes precedence over a sample in the same cycle.
    assign s_ready   = (state_reg == ST_LOAD) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_LOAD);

    // Sequencer and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            size_reg <= 3'd6;
            fill_reg <= '0;
            stage_reg <= '0;
            bfly_reg <= '0;
            emit_reg <= '0;
            sent_reg <= '0;
            rd_pend_reg <= 1'b0;
            ob_valid_reg <= 1'b0;
        end else begin
            if (ob_valid_reg && m_ready) ob_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD: begin
                    if (cfg_valid) begin
                        size_reg <= cfg_data;
                        fill_reg <= '0;
                    end else if (s_valid) begin
                        if ((fill_reg & (npts - (AW+1)'(1))) == npts - (AW+1)'(1)) begin
                            fill_reg <= '0;
                            stage_reg <= eff_log;
                            bfly_reg <= '0;
                            state_reg <= ST_RD_A;
                        end else begin
                            fill_reg <= (fill_reg & (npts - (AW+1)'(1))) + (AW+1)'(1);
                        end
                    end
                end
                ST_RD_A: state_reg <= ST_RD_B;
                ST_RD_B: begin
                    a_re_reg <= rd_re; a_im_reg <= rd_im;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    // Differences kept; first pair of products.
                    d_re_reg <= dif_re; d_im_reg <= dif_im;
                    p1_reg <= 40'(dif_re) * 40'(tw_c);
                    p2_reg <= 40'(dif_im) * 40'(tw_s);
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    acc_reg <= 41'(p1_reg) + 41'(p2_reg);
                    p1_reg <= 40'(d_im_reg) * 40'(tw_c);
                    p2_reg <= 40'(d_re_reg) * 40'(tw_s);
                    state_reg <= ST_WR_A;
                end
                ST_WR_A: begin
                    // Real part parked in a_re_reg, imaginary part in acc.
                    a_re_reg <= round_sat(acc_reg);
                    acc_reg <= 41'(p1_reg) - 41'(p2_reg);
                    state_reg <= ST_WR_B;
                end
                ST_WR_B: begin
                    if (32'(bfly_reg) == (int'(npts) / 2) - 1) begin
                        bfly_reg <= '0;
                        if (stage_reg == 3'd1) begin
                            state_reg <= ST_EMIT;
                            emit_reg <= '0;
                            sent_reg <= '0;
                        end else begin
                            stage_reg <= stage_reg - 3'd1;
                            state_reg <= ST_RD_A;
                        end
                    end else begin
                        bfly_reg <= bfly_reg + AW'(1);
                        state_reg <= ST_RD_A;
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        rd_pend_reg <= 1'b1;
                        rd_idx_reg <= emit_reg;
                        emit_reg <= emit_reg + (AW+1)'(1);
                    end
                    if (rd_pend_reg) begin
                        rd_pend_reg <= 1'b0;
                        ob_valid_reg <= 1'b1;
                        ob_re_reg <= rd_re;
                        ob_im_reg <= rd_im;
                        ob_idx_reg <= 6'(rd_idx_reg);
                        ob_last_reg <= (rd_idx_reg == npts - (AW+1)'(1));
                    end
                    if (ob_valid_reg && m_ready) begin
                        sent_reg <= sent_reg + (AW+1)'(1);
                        if (sent_reg == npts - (AW+1)'(1)) state_reg <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_valid     = ob_valid_reg;
    assign m_bin_re    = ob_re_reg;
    assign m_bin_im    = ob_im_reg;
    assign m_bin_index = ob_idx_reg;
    assign m_last_bin  = ob_last_reg;

    `FFT_ASSERT(a_no_load_busy, !(s_ready && m_valid), "sample taken while bins pending")
    `FFT_ASSERT_NEXT(a_pend_lands, rd_pend_reg, m_valid, "read did not reach output")
    `FFT_ASSERT(a_emit_bound, (state_reg != ST_EMIT) || (emit_reg <= npts), "emit pointer overran the frame")
    `FFT_ASSERT(a_last_stage, stage_reg <= 3'(LogLim), "stage beyond frame size")

endmodule

// ===== hdl/fft_ram.sv =====
// ---------------------------------------------------------------------------
// FFT generic RAM
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module fft_ram #(
    parameter int Width = 23,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // Registered read; a read of the address being written returns the old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
